### hdl/asse_pkg.sv
// Shared constants, types and lookup tables for the seven-segment encoder.
// No dependencies; used by every module in hdl/.
package asse_pkg;

  localparam int unsigned SegBits    = 7;
  localparam int unsigned NumLayouts = 7;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned NumLetters = 26;

  typedef logic [SegBits-1:0] pattern_t;   // gfedcba, bit 0 = segment a
  typedef logic [7:0]         seg_byte_t;
  typedef logic [2:0]         mode_t;

  // ASCII codes of interest
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharMinus  = 8'h2D;

  localparam pattern_t PatBlank = 7'h00;
  localparam pattern_t PatMinus = 7'h40;

  localparam pattern_t DigitPat [NumDigits] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  localparam pattern_t LetterPat [NumLetters] = '{
    7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h76, 7'h19, 7'h0D,
    7'h72, 7'h38, 7'h55, 7'h54, 7'h5D, 7'h73, 7'h67, 7'h50, 7'h6D, 7'h78,
    7'h3E, 7'h1C, 7'h6A, 7'h1D, 7'h6E, 7'h49
  };

  // Output bit position of each source segment a..g, per panel layout
  localparam logic [2:0] LayoutDest [NumLayouts][SegBits] = '{
    '{3'd3, 3'd7, 3'd5, 3'd0, 3'd1, 3'd2, 3'd6},
    '{3'd0, 3'd4, 3'd6, 3'd3, 3'd2, 3'd1, 3'd5},
    '{3'd0, 3'd5, 3'd7, 3'd3, 3'd2, 3'd1, 3'd6},
    '{3'd4, 3'd1, 3'd3, 3'd7, 3'd6, 3'd5, 3'd2},
    '{3'd3, 3'd6, 3'd4, 3'd0, 3'd1, 3'd2, 3'd5},
    '{3'd7, 3'd6, 3'd5, 3'd4, 3'd0, 3'd2, 3'd1},
    '{3'd7, 3'd6, 3'd5, 3'd4, 3'd1, 3'd3, 3'd2}
  };

  // Highest layout code that names a panel
  localparam mode_t LastLayout = mode_t'(NumLayouts - 1);

endpackage

### hdl/asse_char_decode.sv
// Digit / ASCII character to gfedcba segment pattern lookup.
// Depends on asse_pkg.
module asse_char_decode (
  input  logic [7:0]        digit_value_i,
  input  logic [7:0]        character_i,
  output asse_pkg::pattern_t pattern_o
);

  logic       is_digit_char;
  logic       is_upper;
  logic       is_lower;
  logic [4:0] letter_idx;

  assign is_digit_char = (character_i >= asse_pkg::CharZero)   &&
                         (character_i <= asse_pkg::CharNine);
  assign is_upper      = (character_i >= asse_pkg::CharUpperA) &&
                         (character_i <= asse_pkg::CharUpperZ);
  assign is_lower      = (character_i >= asse_pkg::CharLowerA) &&
                         (character_i <= asse_pkg::CharLowerZ);
  // 'A' and 'a' both sit at 1 in the low five bits
  assign letter_idx    = character_i[4:0] - 5'd1;

  always_comb begin
    if (digit_value_i < 8'(asse_pkg::NumDigits)) begin
      pattern_o = asse_pkg::DigitPat[digit_value_i[3:0]];
    end else if (is_digit_char) begin
      pattern_o = asse_pkg::DigitPat[character_i[3:0]];
    end else if (is_upper || is_lower) begin
      pattern_o = asse_pkg::LetterPat[letter_idx];
    end else if (character_i == asse_pkg::CharMinus) begin
      pattern_o = asse_pkg::PatMinus;
    end else begin
      // space and anything unmapped are blank
      pattern_o = asse_pkg::PatBlank;
    end
  end

endmodule

### hdl/asse_remap.sv
// Permutes a gfedcba pattern into one of the panel wiring layouts; unnamed modes give zero.
// Depends on asse_pkg.
module asse_remap (
  input  asse_pkg::pattern_t  pattern_i,
  input  asse_pkg::mode_t     mode_i,
  output asse_pkg::seg_byte_t seg_byte_o
);

  always_comb begin
    seg_byte_o = '0;
    if (mode_i <= asse_pkg::LastLayout) begin
      for (int s = 0; s < asse_pkg::SegBits; s++) begin
        if (pattern_i[s]) begin
          seg_byte_o[asse_pkg::LayoutDest[mode_i][s]] = 1'b1;
        end
      end
    end
  end

endmodule

### hdl/ascii_seven_segment_remap_encoder.sv
// Top level of the seven-segment character encoder with panel wiring remap.
// Depends on asse_pkg, asse_char_decode and asse_remap.
//
//   channel  | ports                                         | handshake
//   ---------+-----------------------------------------------+---------------------------
//   request  | digit_value_i, character_i, wiring_mode_i     | start high, busy low
//   result   | segment_byte_o                                | done_o, one cycle, no stall
//
// Cycles: one transfer per clock; busy never rises. A request taken is held
// in the input register, and its result then passes through the result
// register onto the ports.
// Reset: rst_ni clears the two valid flags only; payload registers are
// left as they are.
// Stalls: none; the receiver takes every done_o cycle.
module ascii_seven_segment_remap_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] digit_value_i,
  input  logic [7:0] character_i,
  input  logic [2:0] wiring_mode_i,
  output logic       done_o,
  output logic [7:0] segment_byte_o
);

  // input stage
  logic                valid_q;
  logic [7:0]          digit_q;
  logic [7:0]          char_q;
  asse_pkg::mode_t     mode_q;

  // result stage
  logic                done_q;
  asse_pkg::seg_byte_t seg_q;

  asse_pkg::pattern_t  pattern;
  asse_pkg::seg_byte_t seg_d;

  // lookup never backs up, so requests are always taken
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= start && !busy;
      done_q  <= valid_q;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      digit_q <= digit_value_i;
      char_q  <= character_i;
      mode_q  <= wiring_mode_i;
    end
    if (valid_q) begin
      seg_q <= seg_d;
    end
  end

  asse_char_decode u_decode (
    .digit_value_i (digit_q),
    .character_i   (char_q),
    .pattern_o     (pattern)
  );

  asse_remap u_remap (
    .pattern_i  (pattern),
    .mode_i     (mode_q),
    .seg_byte_o (seg_d)
  );

  assign done_o         = done_q;
  assign segment_byte_o = seg_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // every strobe traces back to an earlier request
  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 2))
    else $error("done_o without a request two cycles earlier");

  // unnamed layout code gives an all-zero byte
  a_bad_mode_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (mode_q > asse_pkg::LastLayout)) |=> (segment_byte_o == '0))
    else $error("nonzero output for unnamed wiring mode");

  // blank pattern stays blank through the remap
  a_blank_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (pattern == asse_pkg::PatBlank)) |=> (segment_byte_o == '0))
    else $error("blank pattern produced lit segments");

  // remap is a permutation: segment count survives for named layouts
  a_popcount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (mode_q <= asse_pkg::LastLayout)) |=>
      ($countones(segment_byte_o) == $countones($past(pattern))))
    else $error("remap changed the number of lit segments");

endmodule
